/* rtl/lfu_pkg.sv */
// Shared constants and types of the LFU cache with least-recently-used tie break.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int               CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam int                 COUNT_W   = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int                 STAMP_W   = 40;

	typedef enum logic [0:0] {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

/* rtl/lfu_if.sv */
// Valid/ready channel interfaces for cache requests and cache responses.
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if #(
	parameter int KEY_WIDTH   = lfu_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lfu_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic        [KEY_WIDTH-1:0]   lookup_key;
	logic signed [VALUE_WIDTH-1:0] write_value;

	modport source (output valid, operation, lookup_key, write_value, input ready);
	modport sink (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if #(
	parameter int KEY_WIDTH   = lfu_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lfu_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [VALUE_WIDTH-1:0] read_value;
	logic                          evicted;
	logic        [KEY_WIDTH-1:0]   evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

/* rtl/lfu_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/lfu_cache_replacement_top.sv */
// Top level of the LFU key-value cache with least-recently-used tie break.
//
//   Channel    Direction  Handshake        Beat contents
//   req        in         valid / ready    operation, lookup_key, write_value
//   rsp        out        valid / ready    hit, read_value, evicted, evicted_key
//   cfg        in         cfg_we           cfg_wdata (capacity_in_use)
//
// A request is accepted only in the idle state, so one is finished before the next is taken.
// Each scans the entry memory, one slot read per cycle, then passes the drain, write and response states.
// Reset clears the valid bits, occupancy and access clock at once; no clearing pass.
// A waiting response stalls the block only when the next response is ready to load.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_replacement_top #(
	parameter int ENTRIES     = lfu_pkg::ENTRIES_DEF,
	parameter int KEY_WIDTH   = lfu_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lfu_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
	lfu_req_if.sink                        req,
	lfu_rsp_if.source                      rsp
);

	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
		logic [COUNT_W-1:0]     count;
		logic [STAMP_W-1:0]     stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	state_t state_q, state_d;

	logic [CAP_W-1:0]       cap_q;
	logic [STAMP_W-1:0]     clock_q;
	logic [OCC_W-1:0]       occ_q;
	logic [ENTRIES-1:0]     slot_valid_q;
	logic [IDX_W-1:0]       scan_cnt_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       rd_idx_s1;

	op_t                    op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] wval_q;

	logic                   match_found_q;
	logic [IDX_W-1:0]       match_idx_q;
	logic [VALUE_WIDTH-1:0] match_value_q;
	logic [COUNT_W-1:0]     match_count_q;
	logic                   vict_found_q;
	logic [IDX_W-1:0]       vict_idx_q;
	logic [COUNT_W-1:0]     vict_count_q;
	logic [STAMP_W-1:0]     vict_stamp_q;
	logic [KEY_WIDTH-1:0]   vict_key_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;

	logic                   res_hit_q;
	logic [VALUE_WIDTH-1:0] res_rd_q;
	logic                   res_ev_q;
	logic [KEY_WIDTH-1:0]   res_evk_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [VALUE_WIDTH-1:0] out_rd_q;
	logic                   out_ev_q;
	logic [KEY_WIDTH-1:0]   out_evk_q;

	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic                   scan_issue;
	logic                   write_phase;

	logic [ENTRY_W-1:0]     ram_rdata;
	entry_t                 rd_entry;
	entry_t                 wr_entry;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;

	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       cap_eff;
	logic                   cap_zero;
	logic                   need_evict;
	logic                   do_update;
	logic                   do_insert;
	logic                   do_evict;
	logic [IDX_W-1:0]       ins_idx;
	logic [COUNT_W-1:0]     count_inc;
	logic                   rd_slot_valid;
	logic                   better_victim;

	lfu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (scan_cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_entry      = entry_t'(ram_rdata);
	assign rd_slot_valid = slot_valid_q[rd_idx_s1];
	assign better_victim = !vict_found_q || (rd_entry.count < vict_count_q) ||
		((rd_entry.count == vict_count_q) && (rd_entry.stamp < vict_stamp_q));

	assign cap_ext    = CMP_W'(cap_q);
	assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
	assign cap_zero   = (cap_eff == '0);
	assign need_evict = (CMP_W'(occ_q) >= cap_eff);
	assign count_inc  = (match_count_q == COUNT_MAX) ? COUNT_MAX :
		match_count_q + COUNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready   = (state_q == ST_IDLE);
		scan_issue  = (state_q == ST_SCAN);
		write_phase = (state_q == ST_WRITE);
		out_free    = !out_valid_q || rsp.ready;
		out_load    = (state_q == ST_RESP) && out_free;
	end

	assign accept = req.valid && req.ready;

	always_comb begin
		do_update = 1'b0;
		do_insert = 1'b0;
		do_evict  = 1'b0;
		ins_idx   = free_idx_q;
		if (op_q == OP_GET) begin
			do_update = match_found_q;
		end else if (!cap_zero) begin
			if (match_found_q) begin
				do_update = 1'b1;
			end else begin
				do_evict = need_evict && vict_found_q;
				if (do_evict && (!free_found_q || (vict_idx_q < free_idx_q))) begin
					ins_idx = vict_idx_q;
				end
				do_insert = do_evict || free_found_q;
			end
		end
	end

	always_comb begin
		ram_we         = write_phase && (do_update || do_insert);
		ram_waddr      = do_update ? match_idx_q : ins_idx;
		wr_entry.key   = key_q;
		wr_entry.value = (op_q == OP_PUT) ? wval_q : match_value_q;
		wr_entry.count = do_update ? count_inc : COUNT_W'(1);
		wr_entry.stamp = clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cap_q         <= CAP_RESET;
			clock_q       <= '0;
			occ_q         <= '0;
			slot_valid_q  <= '0;
			scan_cnt_q    <= '0;
			rd_valid_s1   <= 1'b0;
			match_found_q <= 1'b0;
			vict_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= scan_issue;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				clock_q       <= clock_q + STAMP_W'(1);
				scan_cnt_q    <= '0;
				match_found_q <= 1'b0;
				vict_found_q  <= 1'b0;
				free_found_q  <= 1'b0;
			end else if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			if (rd_valid_s1) begin
				if (rd_slot_valid && (rd_entry.key == key_q)) begin
					match_found_q <= 1'b1;
				end
				if (rd_slot_valid && better_victim) begin
					vict_found_q <= 1'b1;
				end
				if (!rd_slot_valid) begin
					free_found_q <= 1'b1;
				end
			end
			if (write_phase) begin
				if (do_evict && (vict_idx_q != ins_idx)) begin
					slot_valid_q[vict_idx_q] <= 1'b0;
				end
				if (do_insert) begin
					slot_valid_q[ins_idx] <= 1'b1;
				end
				if (do_insert && !do_evict) begin
					occ_q <= occ_q + OCC_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(req.operation);
			key_q  <= req.lookup_key;
			wval_q <= req.write_value;
		end
		if (rd_valid_s1) begin
			if (rd_slot_valid && (rd_entry.key == key_q) && !match_found_q) begin
				match_idx_q   <= rd_idx_s1;
				match_value_q <= rd_entry.value;
				match_count_q <= rd_entry.count;
			end
			if (rd_slot_valid && better_victim) begin
				vict_idx_q   <= rd_idx_s1;
				vict_count_q <= rd_entry.count;
				vict_stamp_q <= rd_entry.stamp;
				vict_key_q   <= rd_entry.key;
			end
			if (!rd_slot_valid && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		rd_idx_s1 <= scan_cnt_q;
		if (write_phase) begin
			res_hit_q <= match_found_q && ((op_q == OP_GET) || !cap_zero);
			res_rd_q  <= (match_found_q && (op_q == OP_GET)) ? match_value_q : '0;
			res_ev_q  <= do_evict;
			res_evk_q <= do_evict ? vict_key_q : '0;
		end
		if (out_load) begin
			out_hit_q <= res_hit_q;
			out_rd_q  <= res_rd_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_evk_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(occ_q))
		else $error("Occupancy count disagrees with the valid bits.");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("Occupancy exceeds the number of slots.");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && (scan_cnt_q == '0))
		else $error("An accepted beat did not start a scan at slot zero.");

	a_get_never_evicts: assert property (@(posedge clk) disable iff (!arst_n)
		(write_phase && (op_q == OP_GET)) |=> !res_ev_q && !$changed(slot_valid_q))
		else $error("A get changed the valid bits or reported an eviction.");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !(rsp.hit && rsp.evicted))
		else $error("A response reports both a hit and an eviction.");

endmodule
`default_nettype wire
